// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the calibration block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: src/htc_pkg.sv
// ----------------------------------------------------------------------------
// htc_pkg
// Shared constants, register indexes and types of the calibration block.
// ----------------------------------------------------------------------------
package htc_pkg;

    // Default raw sample width
    localparam int RAW_WIDTH_DEF = 16;

    // Result value width
    localparam int OUT_W = 16;

    // Configuration port
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 32;

    // Calibration point register widths
    localparam int HUM_PT_REG_W  = 8;
    localparam int TEMP_PT_REG_W = 10;

    // Point width used inside a lane (wide enough for both channels)
    localparam int PT_W = 10;

    // Humidity upper clamp in whole percent
    localparam int HUM_MAX = 100;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_HUM_LO_PT  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HUM_HI_PT  = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HUM_LO_RAW = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HUM_HI_RAW = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TMP_LO_PT  = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TMP_HI_PT  = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_TMP_LO_RAW = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_TMP_HI_RAW = 4'd7;

    // Zero-span flags of the two channels
    typedef struct packed {
        logic hum;
        logic temp;
    } t_span_err;

    // One finished result
    typedef struct packed {
        logic [OUT_W-1:0] hum;
        logic [OUT_W-1:0] temp;
        logic             hum_err;
        logic             temp_err;
    } t_result;

endpackage

// File: src/htc_div.sv
// ----------------------------------------------------------------------------
// htc_div
// Pipelined restoring divider on magnitudes, one quotient bit per stage.
// ----------------------------------------------------------------------------
module htc_div #(
    parameter int NUM_W = 28,
    parameter int DEN_W = 17
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    input  logic             i_neg,
    output logic             o_valid,
    output logic [NUM_W-1:0] o_quot,
    output logic             o_neg
);

    // Stage k holds partial remainder and the shifting dividend/quotient word
    logic [DEN_W-1:0] r_rem [0:NUM_W];
    logic [NUM_W-1:0] r_nq  [0:NUM_W];
    logic [DEN_W-1:0] r_den [0:NUM_W];
    logic [NUM_W:0]   r_neg;
    logic [NUM_W:0]   r_v;

    logic [DEN_W-1:0] n_rem [1:NUM_W];
    logic [NUM_W-1:0] n_nq  [1:NUM_W];

    // One compare-subtract per stage
    always_comb begin
        logic [DEN_W:0] trial;
        logic [DEN_W:0] diff;
        logic           ge;
        for (int k = 0; k < NUM_W; k++) begin
            trial = {r_rem[k], r_nq[k][NUM_W-1]};
            diff  = trial - {1'b0, r_den[k]};
            ge    = (trial >= {1'b0, r_den[k]});
            n_rem[k+1] = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            n_nq[k+1]  = {r_nq[k][NUM_W-2:0], ge};
        end
    end

    // Valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[NUM_W-1:0], i_valid};
        end
    end

    // Data chain
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= '0;
            r_nq[0]  <= i_num;
            r_den[0] <= i_den;
            r_neg    <= {r_neg[NUM_W-1:0], i_neg};
            for (int k = 1; k <= NUM_W; k++) begin
                r_rem[k] <= n_rem[k];
                r_nq[k]  <= n_nq[k];
                r_den[k] <= r_den[k-1];
            end
        end
    end

    assign o_valid = r_v[NUM_W];
    assign o_quot  = r_nq[NUM_W];
    assign o_neg   = r_neg[NUM_W];

endmodule

// File: src/htc_lane.sv
// ----------------------------------------------------------------------------
// htc_lane
// One interpolation lane: offset, scale, signed divide and add of low point.
// ----------------------------------------------------------------------------
module htc_lane import htc_pkg::*; #(
    parameter int  RAW_W = RAW_WIDTH_DEF,
    parameter int  LPT_W = PT_W,
    localparam int SUM_W = RAW_W + LPT_W + 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic [RAW_W-1:0] i_raw,
    input  logic [RAW_W-1:0] i_lo_raw,
    input  logic [RAW_W-1:0] i_hi_raw,
    input  logic [LPT_W-1:0] i_lo_pt,
    input  logic [LPT_W-1:0] i_hi_pt,
    output logic             o_valid,
    output logic [SUM_W-1:0] o_sum
);

    localparam int DIFF_W = RAW_W + 1;
    localparam int PROD_W = DIFF_W + LPT_W + 1;

    logic               r_v1;
    logic               r_v2;
    logic               r_v3;
    logic [DIFF_W-1:0]  r_diff;
    logic signed [PROD_W-1:0] r_prod;
    logic [SUM_W-1:0]   r_sum;

    logic signed [LPT_W:0]    dpt;
    logic [DIFF_W-1:0]        span;
    logic signed [PROD_W-1:0] prod;
    logic [PROD_W-1:0]        prod_mag;
    logic [DIFF_W-1:0]        span_mag;
    logic                     neg;
    logic                     div_v;
    logic [PROD_W-1:0]        quot;
    logic                     quot_neg;
    logic [SUM_W-1:0]         q_ext;
    logic [SUM_W-1:0]         n_sum;

    // Calibration terms (the user must keep the registers static while items flow; the lane does not enforce this)
    always_comb begin
        dpt  = $signed({1'b0, i_hi_pt}) - $signed({1'b0, i_lo_pt});
        span = {i_hi_raw[RAW_W-1], i_hi_raw} - {i_lo_raw[RAW_W-1], i_lo_raw};
    end

    // Scale and take magnitudes for the divider
    always_comb begin
        prod     = $signed(r_diff) * dpt;
        prod_mag = r_prod[PROD_W-1] ? PROD_W'(-r_prod) : PROD_W'(r_prod);
        span_mag = span[DIFF_W-1] ? DIFF_W'(-span) : span;
        neg      = r_prod[PROD_W-1] ^ span[DIFF_W-1];
    end

    // Restore sign and add low point
    always_comb begin
        q_ext = SUM_W'(quot);
        n_sum = SUM_W'(i_lo_pt) + (quot_neg ? SUM_W'(-q_ext) : q_ext);
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= div_v;
        end
    end

    // Data path registers
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_diff <= {i_raw[RAW_W-1], i_raw} - {i_lo_raw[RAW_W-1], i_lo_raw};
            r_prod <= prod;
            r_sum  <= n_sum;
        end
    end

    htc_div #(
        .NUM_W (PROD_W),
        .DEN_W (DIFF_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_valid (r_v2),
        .i_num   (prod_mag),
        .i_den   (span_mag),
        .i_neg   (neg),
        .o_valid (div_v),
        .o_quot  (quot),
        .o_neg   (quot_neg)
    );

    assign o_valid = r_v3;
    assign o_sum   = r_sum;

endmodule

// File: src/htc_merge.sv
// ----------------------------------------------------------------------------
// htc_merge
// Combines both lanes: clamp, saturate, span errors; output reg and skid.
// ----------------------------------------------------------------------------
module htc_merge import htc_pkg::*; #(
    parameter int SUM_W = 30
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [SUM_W-1:0] i_hum_sum,
    input  logic [SUM_W-1:0] i_temp_sum,
    input  t_span_err        i_span_err,
    input  logic             i_stall,
    output logic             o_advance,
    output logic             o_valid,
    output t_result          o_result
);

`include "assert_macros.svh"

    localparam logic [OUT_W-1:0] S_MIN = {1'b1, {(OUT_W-1){1'b0}}};
    localparam logic [OUT_W-1:0] S_MAX = {1'b0, {(OUT_W-1){1'b1}}};

    logic    r_out_v;
    logic    r_skid_v;
    t_result r_out;
    t_result r_skid;
    t_result res;
    logic    hum_fits;
    logic    temp_fits;
    logic    hum_big;
    logic    out_free;

    // Range checks and final values
    always_comb begin
        hum_fits  = (&i_hum_sum[SUM_W-1:OUT_W-1]) | ~(|i_hum_sum[SUM_W-1:OUT_W-1]);
        temp_fits = (&i_temp_sum[SUM_W-1:OUT_W-1]) | ~(|i_temp_sum[SUM_W-1:OUT_W-1]);
        hum_big   = $signed(i_hum_sum) > $signed(SUM_W'(HUM_MAX));

        res.hum_err  = i_span_err.hum;
        res.temp_err = i_span_err.temp;

        if (i_span_err.hum) begin
            res.hum = '0;
        end else if (hum_big) begin
            res.hum = OUT_W'(HUM_MAX);
        end else if (!hum_fits) begin
            res.hum = S_MIN;
        end else begin
            res.hum = i_hum_sum[OUT_W-1:0];
        end

        if (i_span_err.temp) begin
            res.temp = '0;
        end else if (temp_fits) begin
            res.temp = i_temp_sum[OUT_W-1:0];
        end else begin
            res.temp = i_temp_sum[SUM_W-1] ? S_MIN : S_MAX;
        end
    end

    assign out_free  = !r_out_v || !i_stall;
    assign o_advance = !r_skid_v;

    // Output register and skid control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (out_free) begin
            r_out_v  <= r_skid_v || i_valid;
            r_skid_v <= 1'b0;
        end else if (i_valid && !r_skid_v) begin
            r_skid_v <= 1'b1;
        end
    end

    // Output and skid payload
    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= r_skid_v ? r_skid : res;
        end else if (!r_skid_v) begin
            r_skid <= res;
        end
    end

    assign o_valid  = r_out_v;
    assign o_result = r_out;

    `ASSERT_IMPL(a_skid_behind_out, i_clk, i_rst_n, r_skid_v, r_out_v,
        "skid holds a request while the output register is empty")
    `ASSERT_NEXT(a_skid_drains, i_clk, i_rst_n, r_skid_v && !i_stall, !r_skid_v,
        "skid did not drain when the output was taken")

endmodule

// File: src/humidity_temperature_calibration.sv
// ----------------------------------------------------------------------------
// humidity_temperature_calibration
// Two-point linear calibration of one humidity and one temperature sample.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: i_valid / o_stall carry a request of one raw humidity and
//   one raw temperature sample; it is taken at an edge with i_valid high and
//   o_stall low. Output channel: o_valid / i_stall carry one result request
//   (humidity in percent, temperature in 1/8 degree, two span error flags).
//   Configuration: i_cfg_valid / o_cfg_ready with register index and data;
//   o_cfg_ready is always high. Write registers only while no request is in
//   flight.
//   Path: each lane's offset and scale registers, its bit-per-stage divider
//   and its sum register, then the shared output register.
//   Throughput: one request per cycle while o_stall is low; both lanes run side by side.
//   Reset: synchronous, active low; clears the pipeline and the calibration
//   registers (all zero, so both span errors are set until written).
//   Stall: a stalled result holds on the outputs; one more result parks in a
//   skid register, and only then does o_stall rise and the pipeline freeze.
// ----------------------------------------------------------------------------
module humidity_temperature_calibration import htc_pkg::*; #(
    parameter int RAW_WIDTH = RAW_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [RAW_WIDTH-1:0]  i_humidity_raw,
    input  logic [RAW_WIDTH-1:0]  i_temperature_raw,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [OUT_W-1:0]      o_humidity_percent,
    output logic [OUT_W-1:0]      o_temperature_eighths,
    output logic                  o_humidity_span_error,
    output logic                  o_temperature_span_error,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

`include "assert_macros.svh"

    localparam int SUM_W = RAW_WIDTH + PT_W + 4;

    // Calibration registers
    logic [HUM_PT_REG_W-1:0]  r_hum_lo_pt;
    logic [HUM_PT_REG_W-1:0]  r_hum_hi_pt;
    logic [RAW_WIDTH-1:0]     r_hum_lo_raw;
    logic [RAW_WIDTH-1:0]     r_hum_hi_raw;
    logic [TEMP_PT_REG_W-1:0] r_tmp_lo_pt;
    logic [TEMP_PT_REG_W-1:0] r_tmp_hi_pt;
    logic [RAW_WIDTH-1:0]     r_tmp_lo_raw;
    logic [RAW_WIDTH-1:0]     r_tmp_hi_raw;

    logic             advance;
    logic             accept;
    logic             hum_v;
    logic             temp_v;
    logic [SUM_W-1:0] hum_sum;
    logic [SUM_W-1:0] temp_sum;
    t_span_err        span_err;
    t_result          result;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = !advance;
    assign accept      = i_valid && advance;

    // Configuration writes; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hum_lo_pt  <= '0;
            r_hum_hi_pt  <= '0;
            r_hum_lo_raw <= '0;
            r_hum_hi_raw <= '0;
            r_tmp_lo_pt  <= '0;
            r_tmp_hi_pt  <= '0;
            r_tmp_lo_raw <= '0;
            r_tmp_hi_raw <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_HUM_LO_PT:  r_hum_lo_pt  <= i_cfg_data[HUM_PT_REG_W-1:0];
                REG_HUM_HI_PT:  r_hum_hi_pt  <= i_cfg_data[HUM_PT_REG_W-1:0];
                REG_HUM_LO_RAW: r_hum_lo_raw <= i_cfg_data[RAW_WIDTH-1:0];
                REG_HUM_HI_RAW: r_hum_hi_raw <= i_cfg_data[RAW_WIDTH-1:0];
                REG_TMP_LO_PT:  r_tmp_lo_pt  <= i_cfg_data[TEMP_PT_REG_W-1:0];
                REG_TMP_HI_PT:  r_tmp_hi_pt  <= i_cfg_data[TEMP_PT_REG_W-1:0];
                REG_TMP_LO_RAW: r_tmp_lo_raw <= i_cfg_data[RAW_WIDTH-1:0];
                REG_TMP_HI_RAW: r_tmp_hi_raw <= i_cfg_data[RAW_WIDTH-1:0];
                default: begin
                end
            endcase
        end
    end

    // Zero span per channel
    assign span_err.hum  = (r_hum_lo_raw == r_hum_hi_raw);
    assign span_err.temp = (r_tmp_lo_raw == r_tmp_hi_raw);

    // Humidity lane: whole percent points (half percent dropped)
    htc_lane #(
        .RAW_W (RAW_WIDTH),
        .LPT_W (PT_W)
    ) u_lane_hum (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (advance),
        .i_valid  (accept),
        .i_raw    (i_humidity_raw),
        .i_lo_raw (r_hum_lo_raw),
        .i_hi_raw (r_hum_hi_raw),
        .i_lo_pt  (PT_W'(r_hum_lo_pt[HUM_PT_REG_W-1:1])),
        .i_hi_pt  (PT_W'(r_hum_hi_pt[HUM_PT_REG_W-1:1])),
        .o_valid  (hum_v),
        .o_sum    (hum_sum)
    );

    // Temperature lane: eighth degree points
    htc_lane #(
        .RAW_W (RAW_WIDTH),
        .LPT_W (PT_W)
    ) u_lane_temp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (advance),
        .i_valid  (accept),
        .i_raw    (i_temperature_raw),
        .i_lo_raw (r_tmp_lo_raw),
        .i_hi_raw (r_tmp_hi_raw),
        .i_lo_pt  (PT_W'(r_tmp_lo_pt)),
        .i_hi_pt  (PT_W'(r_tmp_hi_pt)),
        .o_valid  (temp_v),
        .o_sum    (temp_sum)
    );

    // Merge lanes into one result
    htc_merge #(
        .SUM_W (SUM_W)
    ) u_merge (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (hum_v && temp_v),
        .i_hum_sum  (hum_sum),
        .i_temp_sum (temp_sum),
        .i_span_err (span_err),
        .i_stall    (i_stall),
        .o_advance  (advance),
        .o_valid    (o_valid),
        .o_result   (result)
    );

    assign o_humidity_percent       = result.hum;
    assign o_temperature_eighths    = result.temp;
    assign o_humidity_span_error    = result.hum_err;
    assign o_temperature_span_error = result.temp_err;

    `ASSERT_IMPL(a_lanes_in_step, i_clk, i_rst_n, 1'b1, hum_v == temp_v,
        "humidity and temperature lanes out of step")
    `ASSERT_IMPL(a_hum_clamped, i_clk, i_rst_n, o_valid,
        $signed(o_humidity_percent) <= $signed(OUT_W'(HUM_MAX)),
        "humidity result above clamp")
    `ASSERT_IMPL(a_hum_span_zero, i_clk, i_rst_n, o_valid && o_humidity_span_error,
        o_humidity_percent == '0, "humidity span error with nonzero value")

endmodule

// File: tb/htc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htc_checker
// Watches the configuration, input and result channels of the calibration
// block. It keeps its own copy of the calibration registers, predicts the
// reading of every accepted request and compares each result against the
// oldest prediction, field by field.
// ----------------------------------------------------------------------------
module htc_checker import htc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_stall,
    input  logic [RAW_WIDTH_DEF-1:0] i_humidity_raw,
    input  logic [RAW_WIDTH_DEF-1:0] i_temperature_raw,
    input  logic                  i_out_valid,
    input  logic                  i_out_stall,
    input  logic [OUT_W-1:0]      i_humidity_percent,
    input  logic [OUT_W-1:0]      i_temperature_eighths,
    input  logic                  i_humidity_span_error,
    input  logic                  i_temperature_span_error,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_fail_count,
    output int                    o_pending
);

    localparam int RAW_W = RAW_WIDTH_DEF;
    localparam longint S16_MIN = -32768;
    localparam longint S16_MAX = 32767;

    typedef struct {
        logic [HUM_PT_REG_W-1:0]  hum_lo_pt;
        logic [HUM_PT_REG_W-1:0]  hum_hi_pt;
        logic [RAW_W-1:0]         hum_lo_raw;
        logic [RAW_W-1:0]         hum_hi_raw;
        logic [TEMP_PT_REG_W-1:0] tmp_lo_pt;
        logic [TEMP_PT_REG_W-1:0] tmp_hi_pt;
        logic [RAW_W-1:0]         tmp_lo_raw;
        logic [RAW_W-1:0]         tmp_hi_raw;
    } t_cal;

    t_cal    cal;
    t_result readings_due[$];

    function automatic longint sx(logic [RAW_W-1:0] v);
        return longint'($signed(v));
    endfunction

    // straight line through (raw_lo, pt_lo) and (raw_hi, pt_hi), quotient
    // truncated toward zero; the caller rules out a zero span
    function automatic longint line_fit(longint raw, longint raw_lo, longint raw_hi,
                                        longint pt_lo, longint pt_hi);
        return pt_lo + ((raw - raw_lo) * (pt_hi - pt_lo)) / (raw_hi - raw_lo);
    endfunction

    function automatic t_result predict_reading(logic [RAW_W-1:0] h_raw,
                                                logic [RAW_W-1:0] t_raw);
        t_result r;
        longint  v;
        // humidity: whole percent points, clamped at 100
        r.hum_err = (cal.hum_lo_raw == cal.hum_hi_raw);
        if (r.hum_err) begin
            v = 0;
        end else begin
            v = line_fit(sx(h_raw), sx(cal.hum_lo_raw), sx(cal.hum_hi_raw),
                         longint'(cal.hum_lo_pt >> 1), longint'(cal.hum_hi_pt >> 1));
            if (v > HUM_MAX) v = HUM_MAX;
            if (v < S16_MIN) v = S16_MIN;
        end
        r.hum = v[OUT_W-1:0];
        // temperature: eighth degree points, saturated to 16 bits
        r.temp_err = (cal.tmp_lo_raw == cal.tmp_hi_raw);
        if (r.temp_err) begin
            v = 0;
        end else begin
            v = line_fit(sx(t_raw), sx(cal.tmp_lo_raw), sx(cal.tmp_hi_raw),
                         longint'(cal.tmp_lo_pt), longint'(cal.tmp_hi_pt));
            if (v > S16_MAX) v = S16_MAX;
            if (v < S16_MIN) v = S16_MIN;
        end
        r.temp = v[OUT_W-1:0];
        return r;
    endfunction

    task automatic flag_field(string field, longint want, longint got);
        o_fail_count++;
        $error("%s: expected %0d, actual %0d", field, want, got);
    endtask

    // one pass per clock: register writes, new requests, finished results
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            cal = '{default: '0};
            readings_due.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_HUM_LO_PT:  cal.hum_lo_pt  = i_cfg_data[HUM_PT_REG_W-1:0];
                    REG_HUM_HI_PT:  cal.hum_hi_pt  = i_cfg_data[HUM_PT_REG_W-1:0];
                    REG_HUM_LO_RAW: cal.hum_lo_raw = i_cfg_data[RAW_W-1:0];
                    REG_HUM_HI_RAW: cal.hum_hi_raw = i_cfg_data[RAW_W-1:0];
                    REG_TMP_LO_PT:  cal.tmp_lo_pt  = i_cfg_data[TEMP_PT_REG_W-1:0];
                    REG_TMP_HI_PT:  cal.tmp_hi_pt  = i_cfg_data[TEMP_PT_REG_W-1:0];
                    REG_TMP_LO_RAW: cal.tmp_lo_raw = i_cfg_data[RAW_W-1:0];
                    REG_TMP_HI_RAW: cal.tmp_hi_raw = i_cfg_data[RAW_W-1:0];
                    default: ;  // unknown index, write dropped
                endcase
            end

            if (i_in_valid && !i_in_stall)
                readings_due.push_back(predict_reading(i_humidity_raw, i_temperature_raw));

            if (i_out_valid && !i_out_stall) begin
                if (readings_due.size() == 0) begin
                    o_fail_count++;
                    $error("result with no request outstanding: hum %0d temp %0d",
                           $signed(i_humidity_percent), $signed(i_temperature_eighths));
                end else begin
                    want = readings_due.pop_front();
                    if (i_humidity_percent !== want.hum)
                        flag_field("humidity_percent", $signed(want.hum),
                                   $signed(i_humidity_percent));
                    if (i_temperature_eighths !== want.temp)
                        flag_field("temperature_eighths", $signed(want.temp),
                                   $signed(i_temperature_eighths));
                    if (i_humidity_span_error !== want.hum_err)
                        flag_field("humidity_span_error", want.hum_err,
                                   i_humidity_span_error);
                    if (i_temperature_span_error !== want.temp_err)
                        flag_field("temperature_span_error", want.temp_err,
                                   i_temperature_span_error);
                end
            end
        end
        o_pending = readings_due.size();
    end

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the humidity / temperature calibration block. Runs a short
// directed set over reset, typical, extreme and zero-span calibrations, then
// random requests under random calibrations in three traffic phases, with a
// long result hold-off to back up the pipeline. The checker does the scoring.
// ----------------------------------------------------------------------------
module tb import htc_pkg::*;;

    localparam int RAW_W           = RAW_WIDTH_DEF;
    localparam int TAIL_CYCLES     = 40;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int WATCHDOG_LIMIT  = 5000;
    localparam int ITEMS_PER_CAL   = 250;

    typedef struct {
        logic [HUM_PT_REG_W-1:0]  hum_lo_pt;
        logic [HUM_PT_REG_W-1:0]  hum_hi_pt;
        logic [RAW_W-1:0]         hum_lo_raw;
        logic [RAW_W-1:0]         hum_hi_raw;
        logic [TEMP_PT_REG_W-1:0] tmp_lo_pt;
        logic [TEMP_PT_REG_W-1:0] tmp_hi_pt;
        logic [RAW_W-1:0]         tmp_lo_raw;
        logic [RAW_W-1:0]         tmp_hi_raw;
    } t_cal;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_stall;
    logic [RAW_W-1:0]      i_humidity_raw;
    logic [RAW_W-1:0]      i_temperature_raw;
    logic                  o_valid;
    logic                  i_stall;
    logic [OUT_W-1:0]      o_humidity_percent;
    logic [OUT_W-1:0]      o_temperature_eighths;
    logic                  o_humidity_span_error;
    logic                  o_temperature_span_error;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    int   fail_count;
    int   pending;
    int   send_idle_pct;
    int   recv_idle_pct;
    int   quiet_cycles;
    logic hold_off_req;

    humidity_temperature_calibration u_dut (
        .i_clk                    (i_clk),
        .i_rst_n                  (i_rst_n),
        .i_valid                  (i_valid),
        .o_stall                  (o_stall),
        .i_humidity_raw           (i_humidity_raw),
        .i_temperature_raw        (i_temperature_raw),
        .o_valid                  (o_valid),
        .i_stall                  (i_stall),
        .o_humidity_percent       (o_humidity_percent),
        .o_temperature_eighths    (o_temperature_eighths),
        .o_humidity_span_error    (o_humidity_span_error),
        .o_temperature_span_error (o_temperature_span_error),
        .i_cfg_valid              (i_cfg_valid),
        .o_cfg_ready              (o_cfg_ready),
        .i_cfg_index              (i_cfg_index),
        .i_cfg_data               (i_cfg_data)
    );

    htc_checker u_checker (
        .i_clk                    (i_clk),
        .i_rst_n                  (i_rst_n),
        .i_in_valid               (i_valid),
        .i_in_stall               (o_stall),
        .i_humidity_raw           (i_humidity_raw),
        .i_temperature_raw        (i_temperature_raw),
        .i_out_valid              (o_valid),
        .i_out_stall              (i_stall),
        .i_humidity_percent       (o_humidity_percent),
        .i_temperature_eighths    (o_temperature_eighths),
        .i_humidity_span_error    (o_humidity_span_error),
        .i_temperature_span_error (o_temperature_span_error),
        .i_cfg_valid              (i_cfg_valid),
        .i_cfg_ready              (o_cfg_ready),
        .i_cfg_index              (i_cfg_index),
        .i_cfg_data               (i_cfg_data),
        .o_fail_count             (fail_count),
        .o_pending                (pending)
    );

    // 50 MHz clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // result side: random stalls, plus one long hold-off on request
    initial begin
        logic hold_done;
        hold_done = 1'b0;
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_req && !hold_done) begin
                hold_done = 1'b1;
                i_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
            end
            i_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // watchdog: too long without any request moving on any channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // one request; valid stays high unless the sender idles afterwards
    task automatic send_sample(logic [RAW_W-1:0] hum_raw, logic [RAW_W-1:0] tmp_raw);
        i_valid           <= 1'b1;
        i_humidity_raw    <= hum_raw;
        i_temperature_raw <= tmp_raw;
        do @(posedge i_clk); while (o_stall);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    // stop sending, wait for every outstanding result, then let the pipe settle
    task automatic drain_results();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    // full calibration load; unused upper data bits are random and one
    // write goes to an unmapped index
    task automatic apply_cal(t_cal c);
        write_reg(REG_HUM_LO_PT,  {24'($urandom()), c.hum_lo_pt});
        write_reg(REG_HUM_HI_PT,  {24'($urandom()), c.hum_hi_pt});
        write_reg(REG_HUM_LO_RAW, {16'($urandom()), c.hum_lo_raw});
        write_reg(REG_HUM_HI_RAW, {16'($urandom()), c.hum_hi_raw});
        write_reg(REG_TMP_LO_PT,  {22'($urandom()), c.tmp_lo_pt});
        write_reg(REG_TMP_HI_PT,  {22'($urandom()), c.tmp_hi_pt});
        write_reg(REG_TMP_LO_RAW, {16'($urandom()), c.tmp_lo_raw});
        write_reg(REG_TMP_HI_RAW, {16'($urandom()), c.tmp_hi_raw});
        write_reg(CFG_IDX_W'($urandom_range(2**CFG_IDX_W - 1, REG_TMP_HI_RAW + 1)),
                  $urandom());
        i_cfg_valid <= 1'b0;
    endtask

    // second raw point: often equal or very close to the first
    function automatic logic [RAW_W-1:0] pick_span_end(logic [RAW_W-1:0] lo);
        case ($urandom_range(7))
            0:       return lo;
            1:       return lo + RAW_W'($urandom_range(3)) + 1'b1;
            2:       return lo - RAW_W'($urandom_range(3)) - 1'b1;
            default: return RAW_W'($urandom());
        endcase
    endfunction

    function automatic t_cal rand_cal();
        t_cal c;
        c.hum_lo_pt  = HUM_PT_REG_W'($urandom());
        c.hum_hi_pt  = HUM_PT_REG_W'($urandom());
        c.hum_lo_raw = RAW_W'($urandom());
        c.hum_hi_raw = pick_span_end(c.hum_lo_raw);
        c.tmp_lo_pt  = TEMP_PT_REG_W'($urandom());
        c.tmp_hi_pt  = TEMP_PT_REG_W'($urandom());
        c.tmp_lo_raw = RAW_W'($urandom());
        c.tmp_hi_raw = pick_span_end(c.tmp_lo_raw);
        return c;
    endfunction

    // raw sample: mostly anywhere, some on or near the calibration points
    function automatic logic [RAW_W-1:0] pick_raw(logic [RAW_W-1:0] lo,
                                                  logic [RAW_W-1:0] hi);
        case ($urandom_range(7))
            0:       return lo;
            1:       return hi;
            2:       return lo + RAW_W'($urandom_range(8)) - RAW_W'(4);
            3:       return $urandom_range(1) ? 16'h8000 : 16'h7FFF;
            default: return RAW_W'($urandom());
        endcase
    endfunction

    initial begin
        t_cal cal;
        hold_off_req      = 1'b0;
        send_idle_pct     = 0;
        recv_idle_pct     = 0;
        i_rst_n           <= 1'b0;
        i_valid           <= 1'b0;
        i_humidity_raw    <= '0;
        i_temperature_raw <= '0;
        i_cfg_valid       <= 1'b0;
        i_cfg_index       <= '0;
        i_cfg_data        <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // registers still at reset: both spans are zero
        send_sample(16'h8000, 16'h7FFF);
        send_sample(16'h7FFF, 16'h8000);
        drain_results();

        // typical calibration, odd humidity point loses its half percent
        cal = '{8'd40, 8'd181, -16'sd8000, 16'sd24000,
                10'd80, 10'd1000, 16'h8000, 16'h7FFF};
        apply_cal(cal);
        send_sample(16'h8000, 16'h8000);
        send_sample(16'h7FFF, 16'h7FFF);
        send_sample(16'h0000, 16'h0000);
        send_sample(16'hFFFF, 16'hFFFF);
        send_sample(-16'sd8000, 16'h8000);
        send_sample(16'sd24000, 16'h7FFF);
        send_sample(16'sd24001, 16'sd12345);
        drain_results();

        // span of one, falling temperature line: clamp and saturate both ways
        cal = '{8'd0, 8'd255, 16'd0, 16'd1, 10'd1023, 10'd0, 16'd100, 16'd101};
        apply_cal(cal);
        send_sample(16'h7FFF, 16'h7FFF);
        send_sample(16'h8000, 16'h8000);
        send_sample(16'h0000, 16'd100);
        send_sample(16'h0001, 16'd101);
        send_sample(16'hFFFF, 16'd99);
        drain_results();

        // humidity zero span; temperature raw points at opposite extremes
        cal = '{8'd255, 8'd0, 16'h1234, 16'h1234, 10'd0, 10'd1023, 16'h7FFF, 16'h8000};
        apply_cal(cal);
        send_sample(16'h1234, 16'h0000);
        send_sample(16'hFFFF, 16'h7FFF);
        send_sample(16'h8000, 16'h8000);

        // random phases: slow sender / slower receiver, swapped, then none
        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 38 : (ph == 1) ? 83 : 0;
            recv_idle_pct = (ph == 0) ? 83 : (ph == 1) ? 38 : 0;
            for (int k = 0; k < 2; k++) begin
                drain_results();
                cal = rand_cal();
                apply_cal(cal);
                // back the pipeline up while the sender keeps going
                if (ph == 2 && k == 0)
                    hold_off_req = 1'b1;
                repeat (ITEMS_PER_CAL)
                    send_sample(pick_raw(cal.hum_lo_raw, cal.hum_hi_raw),
                                pick_raw(cal.tmp_lo_raw, cal.tmp_hi_raw));
            end
        end

        drain_results();
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
